@@ design/assert_macros.svh @@
// Assertion macros used by the rasteriser design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/clr_pkg.sv @@
// Package for the clipped line rasteriser: types, codes and constants.
`default_nettype none

package clr_pkg;

    // Coordinate width default
    localparam int COORD_BITS_DEFAULT = 16;

    // Configuration port
    localparam int CFG_BITS       = 15;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_CLIP_X_MAX    = 2'd0;
    localparam cfg_index_t REG_CLIP_Y_MAX    = 2'd1;
    localparam cfg_index_t REG_IMAGE_WIDTH   = 2'd2;
    localparam cfg_index_t REG_IMAGE_HEIGHT  = 2'd3;

    localparam logic [CFG_BITS-1:0] RESET_CLIP_X = 15'd1920;
    localparam logic [CFG_BITS-1:0] RESET_CLIP_Y = 15'd1080;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Region code bits
    localparam int RC_BITS = 4;
    typedef logic [RC_BITS-1:0] region_t;

    localparam region_t RC_LEFT   = 4'b0001;
    localparam region_t RC_RIGHT  = 4'b0010;
    localparam region_t RC_BOTTOM = 4'b0100;
    localparam region_t RC_TOP    = 4'b1000;
    localparam region_t RC_INSIDE = 4'b0000;

    // Edge clips allowed before the segment counts as rejected
    localparam int CLIP_LIMIT    = 8;
    localparam int CLIP_CNT_BITS = $clog2(CLIP_LIMIT + 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODES,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ design/clipped_line_rasterizer.sv @@
// Clipped line rasteriser: step commands take 1 cycle, one word per cycle while out is free.
// Load: result 3 + k*(2*COORD_BITS+3) cycles after accept for k edge clips (k up to 8);
// each edge clip runs one shared multiply and a bit-serial divider, one quotient bit a cycle.
// The block takes no new word while a load is clipping.
// Reset (rst_n, async, low) clears the sequencer and line state; no line is active and
// the window and image registers return to 1920 by 1080.
`default_nettype none

`include "assert_macros.svh"

module clipped_line_rasterizer #(
    parameter int COORD_BITS = clr_pkg::COORD_BITS_DEFAULT
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // configuration
    input  wire                           cfg_write,
    input  wire [clr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire [clr_pkg::CFG_BITS-1:0]   cfg_data,
    // command channel
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire                           command,
    input  wire signed [COORD_BITS-1:0]   x_start,
    input  wire signed [COORD_BITS-1:0]   y_start,
    input  wire signed [COORD_BITS-1:0]   x_end,
    input  wire signed [COORD_BITS-1:0]   y_end,
    input  wire [31:0]                    color,
    // pixel channel
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic [31:0]                   pixel_color,
    output logic                          pixel_valid,
    output logic                          on_image,
    output logic                          line_done,
    output logic                          line_rejected
);

    localparam int W  = COORD_BITS;
    localparam int EW = ((W > clr_pkg::CFG_BITS) ? W : clr_pkg::CFG_BITS) + 2;
    localparam int PW = 2 * W;
    localparam int EB = W + 2;
    localparam int DCW = $clog2(PW + 1);
    localparam int CB = clr_pkg::CLIP_CNT_BITS;

    // configuration registers
    logic [clr_pkg::CFG_BITS-1:0] clip_x_max_reg, clip_y_max_reg;
    logic [clr_pkg::CFG_BITS-1:0] image_width_reg, image_height_reg;

    // sequencer and line state
    clr_pkg::state_t       state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  line_active_reg, line_active_next;
    logic signed [W-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [W-1:0]   tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [W:0]            span_x_reg, span_x_next, span_y_reg, span_y_next;
    logic signed [EB-1:0]  err_reg, err_next;
    logic                  neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [31:0]           held_color_reg, held_color_next;
    logic [CB-1:0]         clip_cnt_reg, clip_cnt_next;
    logic [DCW-1:0]        div_cnt_reg, div_cnt_next;

    // clip datapath
    logic signed [W-1:0]   x0_reg, x0_next, y0_reg, y0_next;
    logic signed [W-1:0]   x1_reg, x1_next, y1_reg, y1_next;
    logic [W-1:0]          mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic [W-1:0]          mag_d_reg, mag_d_next;
    logic                  qneg_reg, qneg_next;
    logic                  horiz_reg, horiz_next;
    logic                  upd_end0_reg, upd_end0_next;
    logic signed [W-1:0]   base_reg, base_next, fixed_reg, fixed_next;
    logic [PW-1:0]         quo_reg, quo_next;
    logic [W-1:0]          rem_reg, rem_next;
    logic                  rej_reg, rej_next;

    // output word registers
    logic signed [W-1:0]   px_reg, px_next, py_reg, py_next;
    logic [31:0]           pcol_reg, pcol_next;
    logic                  pval_reg, pval_next, ponimg_reg, ponimg_next;
    logic                  pdone_reg, pdone_next, prej_reg, prej_next;

    // intermediate signals
    logic                  out_free, in_accept;
    clr_pkg::region_t      c0, c1, co;
    logic signed [W:0]     dx, dy;
    logic signed [EW:0]    fix_val, num;
    logic signed [W:0]     op_a, op_d;
    logic signed [W:0]     op_b;
    logic [W:0]            abs_a, abs_b, abs_d;
    logic [W:0]            rem_sh;
    logic [W+1:0]          diff;
    logic [W-1:0]          q_mag;
    logic signed [W:0]     q_s;
    logic signed [W+1:0]   new_val;
    logic signed [EB:0]    e2;
    logic                  step_x, step_y;
    logic signed [W:0]     ld_dx, ld_dy;
    logic [W:0]            ld_span_x, ld_span_y;

    // region code of one point
    function automatic clr_pkg::region_t region_code(logic signed [W-1:0] x,
                                                     logic signed [W-1:0] y,
                                                     logic [clr_pkg::CFG_BITS-1:0] xm,
                                                     logic [clr_pkg::CFG_BITS-1:0] ym);
        clr_pkg::region_t c;
        logic signed [EW-1:0] xe, ye, xme, yme;
        c   = clr_pkg::RC_INSIDE;
        xe  = EW'(x);
        ye  = EW'(y);
        xme = $signed({{(EW-clr_pkg::CFG_BITS){1'b0}}, xm});
        yme = $signed({{(EW-clr_pkg::CFG_BITS){1'b0}}, ym});
        if (x[W-1])
            c = c | clr_pkg::RC_LEFT;
        else if (xe > xme)
            c = c | clr_pkg::RC_RIGHT;
        if (y[W-1])
            c = c | clr_pkg::RC_BOTTOM;
        else if (ye > yme)
            c = c | clr_pkg::RC_TOP;
        return c;
    endfunction

    // magnitude of a signed value one bit wider than a coordinate
    function automatic logic [W:0] mag(logic signed [W:0] v);
        logic [W:0] m;
        m = v[W] ? W'(0) - v : v;
        return m;
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == clr_pkg::ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_max_reg   <= clr_pkg::RESET_CLIP_X;
            clip_y_max_reg   <= clr_pkg::RESET_CLIP_Y;
            image_width_reg  <= clr_pkg::RESET_CLIP_X;
            image_height_reg <= clr_pkg::RESET_CLIP_Y;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                clr_pkg::REG_CLIP_X_MAX:   clip_x_max_reg   <= cfg_data;
                clr_pkg::REG_CLIP_Y_MAX:   clip_y_max_reg   <= cfg_data;
                clr_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                clr_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                   clip_x_max_reg   <= clip_x_max_reg;
            endcase
        end
    end

    // region codes and edge clip operands
    always_comb
    begin
        c0 = region_code(x0_reg, y0_reg, clip_x_max_reg, clip_y_max_reg);
        c1 = region_code(x1_reg, y1_reg, clip_x_max_reg, clip_y_max_reg);
        co = (c0 != clr_pkg::RC_INSIDE) ? c0 : c1;
        dx = (W+1)'(x1_reg) - (W+1)'(x0_reg);
        dy = (W+1)'(y1_reg) - (W+1)'(y0_reg);
        if ((co & (clr_pkg::RC_TOP | clr_pkg::RC_BOTTOM)) != clr_pkg::RC_INSIDE)
        begin
            fix_val = ((co & clr_pkg::RC_TOP) != clr_pkg::RC_INSIDE) ?
                      $signed({{(EW+1-clr_pkg::CFG_BITS){1'b0}}, clip_y_max_reg}) :
                      '0;
            num  = fix_val - (EW+1)'(y0_reg);
            op_a = dx;
            op_d = dy;
        end
        else
        begin
            fix_val = ((co & clr_pkg::RC_RIGHT) != clr_pkg::RC_INSIDE) ?
                      $signed({{(EW+1-clr_pkg::CFG_BITS){1'b0}}, clip_x_max_reg}) :
                      '0;
            num  = fix_val - (EW+1)'(x0_reg);
            op_a = dy;
            op_d = dx;
        end
        // the edge lies between the endpoints, so the offset fits
        op_b  = num[W:0];
        abs_a = mag(op_a);
        abs_b = mag(op_b);
        abs_d = mag(op_d);
    end

    // divider step and quotient apply
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[PW-1]};
        diff    = {1'b0, rem_sh} - {2'b00, mag_d_reg};
        q_mag   = (mag_d_reg == '0) ? '0 : quo_reg[W-1:0];
        q_s     = qneg_reg ? (W+1)'(0) - {1'b0, q_mag} : {1'b0, q_mag};
        new_val = (W+2)'(base_reg) + (W+2)'(q_s);
    end

    // Bresenham step and load spans
    always_comb
    begin
        e2     = {err_reg, 1'b0};
        step_x = e2 > -$signed((EB+1)'(span_y_reg));
        step_y = e2 < $signed((EB+1)'(span_x_reg));
        ld_dx  = (W+1)'(x1_reg) - (W+1)'(x0_reg);
        ld_dy  = (W+1)'(y1_reg) - (W+1)'(y0_reg);
        ld_span_x = mag(ld_dx);
        ld_span_y = mag(ld_dy);
    end

    // sequencer: next state and register updates
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && out_stall;
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        tgt_x_next       = tgt_x_reg;
        tgt_y_next       = tgt_y_reg;
        span_x_next      = span_x_reg;
        span_y_next      = span_y_reg;
        err_next         = err_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        held_color_next  = held_color_reg;
        clip_cnt_next    = clip_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        mag_a_next       = mag_a_reg;
        mag_b_next       = mag_b_reg;
        mag_d_next       = mag_d_reg;
        qneg_next        = qneg_reg;
        horiz_next       = horiz_reg;
        upd_end0_next    = upd_end0_reg;
        base_next        = base_reg;
        fixed_next       = fixed_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        rej_next         = rej_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        pcol_next        = pcol_reg;
        pval_next        = pval_reg;
        ponimg_next      = ponimg_reg;
        pdone_next       = pdone_reg;
        prej_next        = prej_reg;

        unique case (state_reg)
            clr_pkg::ST_IDLE:
            begin
                if (in_accept && (command == clr_pkg::CMD_LOAD))
                begin
                    x0_next         = x_start;
                    y0_next         = y_start;
                    x1_next         = x_end;
                    y1_next         = y_end;
                    held_color_next = color;
                    clip_cnt_next   = '0;
                    state_next      = clr_pkg::ST_CODES;
                end
                else if (in_accept)
                begin
                    out_valid_next = 1'b1;
                    px_next        = '0;
                    py_next        = '0;
                    pcol_next      = '0;
                    pval_next      = 1'b0;
                    ponimg_next    = 1'b0;
                    pdone_next     = 1'b1;
                    prej_next      = 1'b0;
                    if (!line_active_reg || ((cur_x_reg == tgt_x_reg) &&
                                             (cur_y_reg == tgt_y_reg)))
                    begin
                        line_active_next = 1'b0;
                    end
                    else
                    begin
                        px_next     = cur_x_reg;
                        py_next     = cur_y_reg;
                        pcol_next   = held_color_reg;
                        pval_next   = 1'b1;
                        ponimg_next = !cur_x_reg[W-1] && !cur_y_reg[W-1] &&
                                      ($signed(EW'(cur_x_reg)) <
                                       $signed({{(EW-clr_pkg::CFG_BITS){1'b0}},
                                                image_width_reg})) &&
                                      ($signed(EW'(cur_y_reg)) <
                                       $signed({{(EW-clr_pkg::CFG_BITS){1'b0}},
                                                image_height_reg}));
                        err_next = err_reg
                                 - (step_x ? $signed(EB'(span_y_reg)) : $signed(EB'(0)))
                                 + (step_y ? $signed(EB'(span_x_reg)) : $signed(EB'(0)));
                        if (step_x)
                            cur_x_next = neg_x_reg ? cur_x_reg - W'(1) : cur_x_reg + W'(1);
                        if (step_y)
                            cur_y_next = neg_y_reg ? cur_y_reg - W'(1) : cur_y_reg + W'(1);
                        pdone_next = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);
                        if (pdone_next)
                            line_active_next = 1'b0;
                    end
                end
            end

            clr_pkg::ST_CODES:
            begin
                if ((c0 | c1) == clr_pkg::RC_INSIDE)
                begin
                    rej_next   = 1'b0;
                    state_next = clr_pkg::ST_FINISH;
                end
                else if (((c0 & c1) != clr_pkg::RC_INSIDE) ||
                         (clip_cnt_reg == CB'(clr_pkg::CLIP_LIMIT)))
                begin
                    rej_next   = 1'b1;
                    state_next = clr_pkg::ST_FINISH;
                end
                else
                begin
                    mag_a_next    = abs_a[W-1:0];
                    mag_b_next    = abs_b[W-1:0];
                    mag_d_next    = abs_d[W-1:0];
                    qneg_next     = op_a[W] ^ op_b[W] ^ op_d[W];
                    horiz_next    = (co & (clr_pkg::RC_TOP | clr_pkg::RC_BOTTOM))
                                    != clr_pkg::RC_INSIDE;
                    upd_end0_next = (c0 != clr_pkg::RC_INSIDE);
                    base_next     = horiz_next ? x0_reg : y0_reg;
                    fixed_next    = fix_val[W-1:0];
                    state_next    = clr_pkg::ST_MUL;
                end
            end

            clr_pkg::ST_MUL:
            begin
                // shared multiplier; product seeds the divider
                quo_next     = mag_a_reg * mag_b_reg;
                rem_next     = '0;
                div_cnt_next = DCW'(PW);
                state_next   = clr_pkg::ST_DIV;
            end

            clr_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (!diff[W+1])
                begin
                    rem_next = diff[W-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[W-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1))
                    state_next = clr_pkg::ST_UPDATE;
            end

            clr_pkg::ST_UPDATE:
            begin
                if (upd_end0_reg)
                begin
                    x0_next = horiz_reg ? new_val[W-1:0] : fixed_reg;
                    y0_next = horiz_reg ? fixed_reg : new_val[W-1:0];
                end
                else
                begin
                    x1_next = horiz_reg ? new_val[W-1:0] : fixed_reg;
                    y1_next = horiz_reg ? fixed_reg : new_val[W-1:0];
                end
                clip_cnt_next = clip_cnt_reg + CB'(1);
                state_next    = clr_pkg::ST_CODES;
            end

            clr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    px_next        = '0;
                    py_next        = '0;
                    pcol_next      = '0;
                    pval_next      = 1'b0;
                    ponimg_next    = 1'b0;
                    prej_next      = rej_reg;
                    if (rej_reg)
                    begin
                        line_active_next = 1'b0;
                        pdone_next       = 1'b1;
                    end
                    else
                    begin
                        cur_x_next       = x0_reg;
                        cur_y_next       = y0_reg;
                        tgt_x_next       = x1_reg;
                        tgt_y_next       = y1_reg;
                        span_x_next      = ld_span_x;
                        span_y_next      = ld_span_y;
                        neg_x_next       = !(x0_reg < x1_reg);
                        neg_y_next       = !(y0_reg < y1_reg);
                        err_next         = EB'($signed({1'b0, ld_span_x}))
                                         - EB'($signed({1'b0, ld_span_y}));
                        line_active_next = (x0_reg != x1_reg) || (y0_reg != y1_reg);
                        pdone_next       = !line_active_next;
                    end
                    state_next = clr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = clr_pkg::ST_IDLE;
            end
        endcase
    end

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= clr_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            line_active_reg <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            tgt_x_reg       <= '0;
            tgt_y_reg       <= '0;
            span_x_reg      <= '0;
            span_y_reg      <= '0;
            err_reg         <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            held_color_reg  <= '0;
            clip_cnt_reg    <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            line_active_reg <= line_active_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            tgt_x_reg       <= tgt_x_next;
            tgt_y_reg       <= tgt_y_next;
            span_x_reg      <= span_x_next;
            span_y_reg      <= span_y_next;
            err_reg         <= err_next;
            neg_x_reg       <= neg_x_next;
            neg_y_reg       <= neg_y_next;
            held_color_reg  <= held_color_next;
            clip_cnt_reg    <= clip_cnt_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    // datapath and output word
    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        mag_a_reg    <= mag_a_next;
        mag_b_reg    <= mag_b_next;
        mag_d_reg    <= mag_d_next;
        qneg_reg     <= qneg_next;
        horiz_reg    <= horiz_next;
        upd_end0_reg <= upd_end0_next;
        base_reg     <= base_next;
        fixed_reg    <= fixed_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        rej_reg      <= rej_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pcol_reg     <= pcol_next;
        pval_reg     <= pval_next;
        ponimg_reg   <= ponimg_next;
        pdone_reg    <= pdone_next;
        prej_reg     <= prej_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_color   = pcol_reg;
    assign pixel_valid   = pval_reg;
    assign on_image      = ponimg_reg;
    assign line_done     = pdone_reg;
    assign line_rejected = prej_reg;

    // checks
    `ASSERT_IMPL(a_pixel_not_rejected, clk, rst_n, out_valid && pixel_valid, !line_rejected,
                 "pixel word flagged as rejected")
    `ASSERT_IMPL(a_reject_done, clk, rst_n, out_valid && line_rejected, line_done,
                 "rejected line not marked done")
    `ASSERT_CLK(a_clip_bound, clk, rst_n, clip_cnt_reg <= CB'(clr_pkg::CLIP_LIMIT),
                "edge clip count beyond limit")
    `ASSERT_NEXT(a_step_result, clk, rst_n, in_valid && !in_stall && command == clr_pkg::CMD_STEP,
                 out_valid, "step word produced no result")

endmodule

`default_nettype wire
